>>> rtl/wsd_pkg.sv
`default_nettype none
package wsd_pkg;

	localparam int unsigned STEP_LIMIT = 60;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned MOVE_W = 17;
	localparam int unsigned POS_W = 16;
	localparam int unsigned WID_W = 32;
	localparam int unsigned ELAPSED_W = 16;
	localparam int unsigned LIMIT_W = 16;

	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic REG_IDX_DURATION = 1'b0;
	localparam logic REG_IDX_ACCUM = 1'b1;

	localparam logic [LIMIT_W-1:0] DURATION_RESET = 16'd1;
	localparam logic [LIMIT_W-1:0] ACCUM_RESET = 16'd800;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [MOVE_W-1:0] MOVE_MAX = '1;

	typedef struct packed {
		logic [LIMIT_W-1:0] duration_limit;
		logic [LIMIT_W-1:0] accumulation_limit;
	} cfg_t;

endpackage
`default_nettype wire

>>> rtl/wsd_if.sv
`default_nettype none
interface wsd_in_if;
	import wsd_pkg::*;
	logic                        valid;
	logic                        ready;
	logic                        cmd;
	logic [ELAPSED_W-1:0]        elapsed;
	logic [WID_W-1:0]            window_id;
	logic signed [POS_W-1:0]     pos_x;
	logic signed [POS_W-1:0]     pos_y;

	modport source (output valid, cmd, elapsed, window_id, pos_x, pos_y, input ready);
	modport sink (input valid, cmd, elapsed, window_id, pos_x, pos_y, output ready);
endinterface

interface wsd_out_if;
	import wsd_pkg::*;
	logic                        valid;
	logic                        ready;
	logic                        shake_detected;
	logic [MOVE_W-1:0]           movement_total;

	modport source (output valid, shake_detected, movement_total, input ready);
	modport sink (input valid, shake_detected, movement_total, output ready);
endinterface
`default_nettype wire

>>> rtl/wsd_cfg.sv
`default_nettype none
module wsd_cfg
	import wsd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	cfg_t cfg_q;
	logic reg_idx;
	logic wr_en;

	assign pready = 1'b1;
	assign reg_idx = paddr[2];
	assign wr_en = psel && penable && pwrite && pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.duration_limit <= DURATION_RESET;
			cfg_q.accumulation_limit <= ACCUM_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_IDX_DURATION: cfg_q.duration_limit <= pwdata[LIMIT_W-1:0];
				REG_IDX_ACCUM: cfg_q.accumulation_limit <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_IDX_DURATION: prdata = {{(CFG_DATA_W-LIMIT_W){1'b0}}, cfg_q.duration_limit};
			REG_IDX_ACCUM: prdata = {{(CFG_DATA_W-LIMIT_W){1'b0}}, cfg_q.accumulation_limit};
			default: prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/wsd_core.sv
`default_nettype none
module wsd_core
	import wsd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  cfg_t       cfg,
	wsd_in_if.sink     items,
	wsd_out_if.source  results
);

	// input register
	logic                    valid_s1;
	logic                    cmd_s1;
	logic [ELAPSED_W-1:0]    elapsed_s1;
	logic [WID_W-1:0]        window_id_s1;
	logic signed [POS_W-1:0] pos_x_s1;
	logic signed [POS_W-1:0] pos_y_s1;

	// result register
	logic                    valid_s2;
	logic                    shake_s2;
	logic [MOVE_W-1:0]       movement_s2;

	// detector state
	logic [TIME_W-1:0]       time_q;
	logic [MOVE_W-1:0]       move_q;
	logic signed [POS_W-1:0] last_x_q;
	logic signed [POS_W-1:0] last_y_q;
	logic [WID_W-1:0]        last_window_q;
	logic                    seen_q;

	logic                    adv_s2;
	logic                    proc;
	logic                    time_over;
	logic                    move_over;
	logic                    shake_c;
	logic [TIME_W-1:0]       time_a;
	logic [MOVE_W-1:0]       move_a;
	logic [TIME_W:0]         time_add;
	logic [TIME_W-1:0]       time_b;
	logic                    new_win;
	logic signed [POS_W-1:0] ref_x;
	logic signed [POS_W-1:0] ref_y;
	logic signed [POS_W:0]   dx;
	logic signed [POS_W:0]   dy;
	logic [POS_W-1:0]        adx;
	logic [POS_W-1:0]        ady;
	logic [MOVE_W-1:0]       step;
	logic                    step_ok;
	logic [MOVE_W:0]         move_add;
	logic [TIME_W-1:0]       time_n;
	logic [MOVE_W-1:0]       move_n;

	assign adv_s2 = !valid_s2 || results.ready;
	assign proc = valid_s1 && adv_s2;
	assign items.ready = !valid_s1 || adv_s2;

	always_comb begin
		time_over = time_q >= {{(TIME_W-LIMIT_W){1'b0}}, cfg.duration_limit};
		move_over = move_q >= {1'b0, cfg.accumulation_limit};
		shake_c = !time_over && move_over;
		time_a = (time_over || move_over) ? '0 : time_q;
		move_a = (time_over || move_over) ? '0 : move_q;

		time_add = {1'b0, time_a} + {{(TIME_W+1-ELAPSED_W){1'b0}}, elapsed_s1};
		time_b = time_add[TIME_W] ? TIME_MAX : time_add[TIME_W-1:0];

		new_win = !seen_q || (window_id_s1 != last_window_q);
		ref_x = new_win ? pos_x_s1 : last_x_q;
		ref_y = new_win ? pos_y_s1 : last_y_q;
		dx = {pos_x_s1[POS_W-1], pos_x_s1} - {ref_x[POS_W-1], ref_x};
		dy = {pos_y_s1[POS_W-1], pos_y_s1} - {ref_y[POS_W-1], ref_y};
		adx = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
		ady = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
		step = {1'b0, adx} + {1'b0, ady};
		step_ok = step <= MOVE_W'(STEP_LIMIT);
		move_add = {1'b0, new_win ? {MOVE_W{1'b0}} : move_a} + {1'b0, step};

		time_n = time_b;
		move_n = move_a;
		if (cmd_s1) begin
			if (!step_ok) begin
				time_n = '0;
				move_n = '0;
			end else begin
				time_n = new_win ? '0 : time_b;
				move_n = move_add[MOVE_W] ? MOVE_MAX : move_add[MOVE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			cmd_s1 <= items.cmd;
			elapsed_s1 <= items.elapsed;
			window_id_s1 <= items.window_id;
			pos_x_s1 <= items.pos_x;
			pos_y_s1 <= items.pos_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			move_q <= '0;
			last_x_q <= '0;
			last_y_q <= '0;
			last_window_q <= '0;
			seen_q <= 1'b0;
		end else if (proc) begin
			time_q <= time_n;
			move_q <= move_n;
			if (cmd_s1) begin
				last_x_q <= pos_x_s1;
				last_y_q <= pos_y_s1;
				last_window_q <= window_id_s1;
				seen_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			shake_s2 <= shake_c;
			movement_s2 <= move_n;
		end
	end

	assign results.valid = valid_s2;
	assign results.shake_detected = shake_s2;
	assign results.movement_total = movement_s2;

	a_seen_after_move: assert property (@(posedge clk) disable iff (!arst_n)
		proc && cmd_s1 |=> seen_q)
		else $error("window not marked seen after a move word");

	a_shake_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		proc && move_over && !time_over |=> valid_s2 && shake_s2)
		else $error("shake not flagged with movement over limit");

	a_big_step_clears: assert property (@(posedge clk) disable iff (!arst_n)
		proc && cmd_s1 && !new_win && !step_ok |=> time_q == '0 && move_q == '0)
		else $error("large step did not clear sums");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !results.ready |-> !items.ready)
		else $error("input taken while both stages full and stalled");

	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		proc |=> movement_s2 == move_q)
		else $error("result word differs from movement state");

endmodule
`default_nettype wire

>>> rtl/window_shake_detector_top.sv
// Window shake detector.
// items (wsd_in_if, sink): one word per device report, carrying elapsed time
// and, when cmd is set, a window move event (window_id, pos_x, pos_y).
// results (wsd_out_if, source): one word per input word, with shake_detected
// and the saturated movement_total after that step.
// Configuration: APB-style write/read of duration_limit (0x0) and
// accumulation_limit (0x4); write only while no word is in flight.
// Path: a word accepted on items is held in the input register, then the
// step outcome is written to the result register.
// Throughput: one word per cycle unless results stalls; the combinational
// update of the time and movement sums sets this figure.
// Stall: with a result held and results.ready low, the result register
// holds; an empty input register takes a last word, then items.ready drops.
// Reset (arst_n low): sums, last position, last window and the seen flag
// clear; limits return to 1 and 800; both registers empty.
`default_nettype none
module window_shake_detector_top
	import wsd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	wsd_in_if.sink                     items,
	wsd_out_if.source                  results,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready
);

	cfg_t cfg;

	wsd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wsd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.items   (items),
		.results (results)
	);

endmodule
`default_nettype wire
